### design/grow_light_on_off_controller_macros.svh
// ----------------------------------------------------------------------------
// grow light controller assertion macros
// clocked property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef GROW_LIGHT_ON_OFF_CONTROLLER_MACROS_SVH
`define GROW_LIGHT_ON_OFF_CONTROLLER_MACROS_SVH

// same-cycle implication, off while in reset
`define GLOOC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("glooc assertion failed");

// next-cycle implication, off while in reset
`define GLOOC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("glooc assertion failed");

// next-cycle implication that also checks across reset
`define GLOOC_ASSERT_NXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("glooc assertion failed");

`endif

### design/glooc_pkg.sv
// ----------------------------------------------------------------------------
// glooc_pkg
// types, register map and helpers of the grow light on/off controller
// ----------------------------------------------------------------------------
package glooc_pkg;

  localparam int TIMER_BITS   = 20;
  localparam int LEVEL_W      = 12;
  localparam int SUM_W        = 16;
  localparam int MIN_ON_W     = 20;
  localparam int TICK_W       = 12;
  localparam int OUT_TIME_W   = 20;
  localparam int CMP_W        = (TIMER_BITS > MIN_ON_W) ? TIMER_BITS : MIN_ON_W;
  localparam int CMP_OUT_W    = (TIMER_BITS > OUT_TIME_W) ? TIMER_BITS : OUT_TIME_W;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 24;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = ADDR_W - 2;

  localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX    = '1;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_THRESH = 2'd1,
    MODE_SUM    = 2'd2,
    MODE_ON     = 2'd3
  } mode_t;

  localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TH_LOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TH_HIGH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_ON  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TICK    = 3'd5;

  typedef struct packed {
    mode_t                mode;
    logic [LEVEL_W-1:0]   th_low;
    logic [LEVEL_W-1:0]   th_high;
    logic [SUM_W-1:0]     target_sum;
    logic [MIN_ON_W-1:0]  min_on;
    logic [TICK_W-1:0]    tick;
  } cfg_t;

  typedef struct packed {
    logic                  lamp;
    logic                  latch;
    logic [TIMER_BITS-1:0] timer;
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SUM_W-1:0]   sum;
    logic               midnight;
  } item_t;

  // reported on-time, clipped to the output field
  function automatic logic [OUT_TIME_W-1:0] report_time(input logic [TIMER_BITS-1:0] t);
    logic [CMP_OUT_W-1:0] ext;
    begin
      ext = CMP_OUT_W'(t);
      if (ext > CMP_OUT_W'(OUT_TIME_MAX)) begin
        return OUT_TIME_MAX;
      end
      return ext[OUT_TIME_W-1:0];
    end
  endfunction

endpackage

### design/glooc_regs.sv
// ----------------------------------------------------------------------------
// glooc_regs
// apb configuration registers of the grow light controller
// ----------------------------------------------------------------------------
module glooc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glooc_pkg::ADDR_W-1:0]  paddr,
  input  logic [glooc_pkg::DATA_W-1:0]  pwdata,
  output logic [glooc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output glooc_pkg::cfg_t               cfg
);

  glooc_pkg::cfg_t                     cfg_r;
  logic                                wr_en;
  logic [glooc_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[glooc_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= glooc_pkg::MODE_OFF;
      cfg_r.th_low     <= '0;
      cfg_r.th_high    <= '0;
      cfg_r.target_sum <= '1;
      cfg_r.min_on     <= '0;
      cfg_r.tick       <= glooc_pkg::TICK_W'(300);
    end else if (wr_en) begin
      unique case (idx)
        glooc_pkg::REG_MODE:    cfg_r.mode       <= glooc_pkg::mode_t'(pwdata[1:0]);
        glooc_pkg::REG_TH_LOW:  cfg_r.th_low     <= pwdata[glooc_pkg::LEVEL_W-1:0];
        glooc_pkg::REG_TH_HIGH: cfg_r.th_high    <= pwdata[glooc_pkg::LEVEL_W-1:0];
        glooc_pkg::REG_TARGET:  cfg_r.target_sum <= pwdata[glooc_pkg::SUM_W-1:0];
        glooc_pkg::REG_MIN_ON:  cfg_r.min_on     <= pwdata[glooc_pkg::MIN_ON_W-1:0];
        glooc_pkg::REG_TICK:    cfg_r.tick       <= pwdata[glooc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      glooc_pkg::REG_MODE:    prdata = glooc_pkg::DATA_W'(cfg_r.mode);
      glooc_pkg::REG_TH_LOW:  prdata = glooc_pkg::DATA_W'(cfg_r.th_low);
      glooc_pkg::REG_TH_HIGH: prdata = glooc_pkg::DATA_W'(cfg_r.th_high);
      glooc_pkg::REG_TARGET:  prdata = glooc_pkg::DATA_W'(cfg_r.target_sum);
      glooc_pkg::REG_MIN_ON:  prdata = glooc_pkg::DATA_W'(cfg_r.min_on);
      glooc_pkg::REG_TICK:    prdata = glooc_pkg::DATA_W'(cfg_r.tick);
      default:                prdata = '0;
    endcase
  end

endmodule

### design/glooc_decide.sv
// ----------------------------------------------------------------------------
// glooc_decide
// per-tick lamp decision, daily latch and on-time counter update
// ----------------------------------------------------------------------------
module glooc_decide (
  input  glooc_pkg::cfg_t    cfg,
  input  glooc_pkg::state_t  cur,
  input  glooc_pkg::item_t   item,
  output glooc_pkg::state_t  nxt
);

  logic                                hyst_on;
  logic                                on_pre;
  logic                                latch_nxt;
  logic [glooc_pkg::TIMER_BITS:0]      timer_sum;
  logic [glooc_pkg::TIMER_BITS-1:0]    timer_inc;
  logic                                turn_on;
  logic                                hold_on;

  // hysteresis: stay on until above high, come on only below low
  assign hyst_on = cur.lamp ? !(item.level > cfg.th_high) : (item.level < cfg.th_low);

  always_comb begin
    on_pre    = cur.lamp;
    latch_nxt = 1'b0;
    unique case (cfg.mode)
      glooc_pkg::MODE_OFF: begin
        on_pre = 1'b0;
      end
      glooc_pkg::MODE_THRESH: begin
        on_pre = hyst_on;
      end
      glooc_pkg::MODE_SUM: begin
        latch_nxt = !item.midnight && (cur.latch || (item.sum > cfg.target_sum));
        on_pre    = hyst_on && !latch_nxt;
      end
      glooc_pkg::MODE_ON: begin
        on_pre = 1'b1;
      end
      default: begin
        on_pre = 1'b0;
      end
    endcase
  end

  assign timer_sum = {1'b0, cur.timer} + (glooc_pkg::TIMER_BITS+1)'(cfg.tick);
  assign timer_inc = timer_sum[glooc_pkg::TIMER_BITS] ? glooc_pkg::TIMER_MAX
                                                      : timer_sum[glooc_pkg::TIMER_BITS-1:0];
  assign turn_on   = !cur.lamp && on_pre;
  // a switch-off before the minimum on-time is overruled, latch included
  assign hold_on   = cur.lamp && !on_pre &&
                     (glooc_pkg::CMP_W'(timer_inc) < glooc_pkg::CMP_W'(cfg.min_on));

  assign nxt.timer = turn_on ? '0 : timer_inc;
  assign nxt.lamp  = on_pre | hold_on;
  assign nxt.latch = latch_nxt;

endmodule

### design/grow_light_on_off_controller.sv
// an input transaction passes the input register, then the output register
// throughput: one per cycle unless stalled, limited by the single decision stage
// output stalls back up through the input register into in_tready
// reset (rst_n, synchronous, active low) turns the lamp off, clears the latch
// and on-time counter, and loads the registers with their reset values
// ----------------------------------------------------------------------------
// grow_light_on_off_controller
// grow light on/off control with hysteresis, daily light sum and min on-time
// ----------------------------------------------------------------------------
module grow_light_on_off_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // [11:0] light_level, [27:12] light_sum_today, [31:28] zero
  input  logic [glooc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] is_midnight
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] lamp_on, [20:1] on_time_seconds, [21] done_for_today, [23:22] zero
  output logic [glooc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [glooc_pkg::ADDR_W-1:0]       paddr,
  input  logic [glooc_pkg::DATA_W-1:0]       pwdata,
  output logic [glooc_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  glooc_pkg::cfg_t                          cfg;
  glooc_pkg::state_t                        state_r;
  glooc_pkg::state_t                        state_nxt;
  glooc_pkg::item_t                         item_r;
  logic                                     item_valid_r;
  logic                                     out_valid_r;
  logic [glooc_pkg::OUT_TDATA_W-1:0]        out_data_r;
  logic                                     advance;
  logic                                     in_xact;

  glooc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  glooc_decide u_decide (
    .cfg  (cfg),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt)
  );

  // the output register moves whenever it is empty or being drained
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !item_valid_r || advance;
  assign in_xact    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_xact) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
        if (item_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      item_r.level    <= in_tdata[glooc_pkg::LEVEL_W-1:0];
      item_r.sum      <= in_tdata[glooc_pkg::LEVEL_W +: glooc_pkg::SUM_W];
      item_r.midnight <= in_tuser;
    end
    if (advance && item_valid_r) begin
      out_data_r <= {2'b00, state_nxt.latch,
                     glooc_pkg::report_time(state_nxt.timer), state_nxt.lamp};
    end
  end

endmodule

### design/glooc_checker.sv
// ----------------------------------------------------------------------------
// glooc_checker
// port-level checks of the grow light controller, bound to the top level
// ----------------------------------------------------------------------------
`include "grow_light_on_off_controller_macros.svh"

module glooc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic [glooc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  logic last_lamp_r;
  logic out_xact;
  logic lamp_bit;
  logic time_zero;

  assign out_xact  = out_tvalid && out_tready;
  assign lamp_bit  = out_tdata[0];
  assign time_zero = (out_tdata[glooc_pkg::OUT_TIME_W:1] == '0);

  // lamp state of the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lamp_r <= 1'b0;
    end else if (out_xact) begin
      last_lamp_r <= lamp_bit;
    end
  end

  `GLOOC_ASSERT_NXT(out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `GLOOC_ASSERT_NXT_RST(rst_clears_out, !rst_n, !out_tvalid)
  `GLOOC_ASSERT_IMP(ready_when_drained, !out_tvalid, in_tready)
  `GLOOC_ASSERT_IMP(turn_on_zero_time, out_xact && lamp_bit && !last_lamp_r, time_zero)

endmodule

bind grow_light_on_off_controller glooc_checker u_glooc_checker (.*);
